FILE: sv/xsd_pkg.sv
// Shared types and constants for the XOR sprite framebuffer.
// Used by xsd_ctrl, xsd_datapath and xor_sprite_draw_framebuffer_core.
package xsd_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 64;
  localparam int unsigned DEF_SCREEN_HEIGHT = 32;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int unsigned ROW_BITS = 8;

  // Shift-subtract steps of the modulo reducer. Values reduced stay below
  // 64 times the modulus over the whole parameter range (line <= 270 with
  // height >= 8, base < size + 256 with size >= 64).
  localparam int unsigned RED_STEPS = 6;
  localparam int unsigned CNT_W     = 4;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_LINE   = 9'b000000100,
    ST_BASE   = 9'b000001000,
    ST_WRAP   = 9'b000010000,
    ST_ADDR   = 9'b000100000,
    ST_PIX    = 9'b001000000,
    ST_RDMEM  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } xsd_state_e;

  typedef struct packed {
    logic             accept;
    logic             clr_start;
    logic             red_step;
    logic [CNT_W-1:0] red_shift;
    logic             red_mod_fb;
    logic             base_load;
    logic             addr_load;
    logic             addr_inc;
    logic             mem_rd;
    logic             pix_shift;
    logic             pix_wr;
    logic             clr_wr;
    logic             finish;
  } xsd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } xsd_sts_t;

endpackage

FILE: sv/xsd_datapath.sv
// Datapath of the XOR sprite framebuffer: field latches, modulo reducer,
// pixel store with registered read, collision tracking and result register.
// Depends on xsd_pkg; driven by xsd_ctrl commands.
module xsd_datapath #(
  parameter int unsigned SCREEN_WIDTH  = xsd_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = xsd_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xsd_pkg::xsd_cmd_t cmd_i,
  output xsd_pkg::xsd_sts_t sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        x_pos_i,
  input  logic [7:0]        y_pos_i,
  input  logic [3:0]        row_index_i,
  input  logic [7:0]        sprite_bits_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              row_collision_o,
  output logic              sprite_collision_o,
  output logic              pixel_value_o
);
  import xsd_pkg::*;

  localparam int unsigned FB_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW      = $clog2(FB_SIZE);
  localparam int unsigned LW      = $clog2(SCREEN_HEIGHT);
  localparam int unsigned VW      = AW + 4;
  localparam int unsigned CW      = VW + RED_STEPS;

  logic [1:0]          op_q;
  logic [3:0]          row_q;
  logic [7:0]          x_q;
  logic [ROW_BITS-1:0] bits_q;
  logic                wbit_q;
  logic [VW-1:0]       red_q, red_d;
  logic [CW-1:0]       mod_ext, sub_ext, red_ext;
  logic [AW-1:0]       addr_q, addr_nxt, waddr_q;
  logic                mem_q [FB_SIZE];
  logic                rd_q;
  logic                hit_q, seen_q, seen_new;
  logic                out_valid_q, row_col_q, spr_col_q, pix_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign sts_o.out_free = out_free;
  assign sts_o.clr_last = (addr_q == AW'(FB_SIZE - 1));

  // One conditional subtract of the shifted modulus per step.
  always_comb begin
    mod_ext = cmd_i.red_mod_fb ? CW'(FB_SIZE) : CW'(SCREEN_HEIGHT);
    sub_ext = mod_ext << cmd_i.red_shift;
    red_ext = CW'(red_q);
    red_d   = red_q;
    if (red_ext >= sub_ext) begin
      red_d = VW'(red_ext - sub_ext);
    end
  end

  assign addr_nxt = (addr_q == AW'(FB_SIZE - 1)) ? '0 : addr_q + 1'b1;
  assign seen_new = ((row_q == 4'd0) ? 1'b0 : seen_q) | hit_q;

  // Item fields and address arithmetic.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      row_q  <= row_index_i;
      x_q    <= x_pos_i;
      bits_q <= sprite_bits_i;
      if (opcode_i == OP_DRAW) begin
        red_q <= VW'(y_pos_i) + VW'(row_index_i);
      end else begin
        red_q <= VW'(y_pos_i);
      end
    end else if (cmd_i.base_load) begin
      red_q <= VW'(x_q) + VW'(red_q[LW-1:0]) * VW'(SCREEN_WIDTH);
    end else if (cmd_i.red_step) begin
      red_q <= red_d;
    end
    if (cmd_i.pix_shift) begin
      bits_q  <= bits_q << 1;
      wbit_q  <= bits_q[ROW_BITS-1];
      waddr_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.clr_start) begin
      addr_q <= '0;
    end else if (cmd_i.addr_load) begin
      addr_q <= red_q[AW-1:0];
    end else if (cmd_i.addr_inc) begin
      addr_q <= addr_nxt;
    end
  end

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[addr_q] <= 1'b0;
    end else if (cmd_i.pix_wr && wbit_q) begin
      mem_q[waddr_q] <= ~rd_q;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        hit_q <= 1'b0;
      end else if (cmd_i.pix_wr && wbit_q && rd_q) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.finish && out_free) begin
        out_valid_q <= 1'b1;
        if (op_q == OP_DRAW) begin
          seen_q <= seen_new;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && out_free) begin
      row_col_q <= (op_q == OP_DRAW) && hit_q;
      spr_col_q <= (op_q == OP_DRAW) && seen_new;
      pix_q     <= (op_q == OP_READ) && rd_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign row_collision_o    = row_col_q;
  assign sprite_collision_o = spr_col_q;
  assign pixel_value_o      = pix_q;

endmodule

FILE: sv/xsd_ctrl.sv
// Controller of the XOR sprite framebuffer: sequences address reduction,
// the pixel read-modify-write loop, clearing sweeps and result hand-off.
// Depends on xsd_pkg; commands xsd_datapath.
module xsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  xsd_pkg::xsd_sts_t sts_i,
  output xsd_pkg::xsd_cmd_t cmd_o
);
  import xsd_pkg::*;

  xsd_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             clr_item_q, clr_item_d;
  logic             draw_q, draw_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_item_d = clr_item_q;
    draw_d     = draw_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.addr_inc = 1'b1;
        if (sts_i.clr_last) begin
          state_d = clr_item_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          clr_item_d   = (opcode_i == OP_CLEAR);
          draw_d       = (opcode_i == OP_DRAW);
          cnt_d        = CNT_W'(RED_STEPS - 1);
          if (opcode_i == OP_DRAW || opcode_i == OP_READ) begin
            state_d = ST_LINE;
          end else if (opcode_i == OP_CLEAR) begin
            cmd_o.clr_start = 1'b1;
            state_d         = ST_CLEAR;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LINE: begin
        cmd_o.red_step  = 1'b1;
        cmd_o.red_shift = cnt_q;
        if (cnt_q == '0) begin
          state_d = ST_BASE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_BASE: begin
        cmd_o.base_load = 1'b1;
        cnt_d           = CNT_W'(RED_STEPS - 1);
        state_d         = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.red_step   = 1'b1;
        cmd_o.red_mod_fb = 1'b1;
        cmd_o.red_shift  = cnt_q;
        if (cnt_q == '0) begin
          state_d = ST_ADDR;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_load = 1'b1;
        cnt_d           = '0;
        state_d         = draw_q ? ST_PIX : ST_RDMEM;
      end
      ST_PIX: begin
        // Read pixel n while writing back pixel n-1.
        if (cnt_q < CNT_W'(ROW_BITS)) begin
          cmd_o.mem_rd    = 1'b1;
          cmd_o.addr_inc  = 1'b1;
          cmd_o.pix_shift = 1'b1;
        end
        if (cnt_q != '0) begin
          cmd_o.pix_wr = 1'b1;
        end
        if (cnt_q == CNT_W'(ROW_BITS)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RDMEM: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      clr_item_q <= 1'b0;
      draw_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clr_item_q <= clr_item_d;
      draw_q     <= draw_d;
    end
  end

endmodule

FILE: sv/xor_sprite_draw_framebuffer_core.sv
// XOR sprite framebuffer, one bit per pixel, SCREEN_WIDTH x SCREEN_HEIGHT.
// One item at a time. A draw runs two 6-step modulo reductions and an 8-pixel
// read-modify-write loop before its result, a read the same two reductions and
// one store read, a clear a sweep that clears one store entry per cycle.
// A new item is taken only in idle, which is entered as the previous result is registered.
// Reset: asynchronous, active low; a clearing pass over all W*H entries follows.
module xor_sprite_draw_framebuffer_core #(
  parameter int unsigned SCREEN_WIDTH  = xsd_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = xsd_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [3:0] row_index_i,
  input  logic [7:0] sprite_bits_i,
  input  logic       last_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       row_collision_o,
  output logic       sprite_collision_o,
  output logic       pixel_value_o
);
  import xsd_pkg::*;

  xsd_cmd_t cmd;
  xsd_sts_t sts;

  // last_row_i carries no behavior: accumulation restarts at the next row 0.

  xsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  xsd_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .x_pos_i            (x_pos_i),
    .y_pos_i            (y_pos_i),
    .row_index_i        (row_index_i),
    .sprite_bits_i      (sprite_bits_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .row_collision_o    (row_collision_o),
    .sprite_collision_o (sprite_collision_o),
    .pixel_value_o      (pixel_value_o)
  );

endmodule

FILE: tb/xsd_checker.sv
// Checker for the XOR sprite framebuffer: mirrors the pixel store and the collision flag,
// predicts one flag set per accepted item and compares it with each accepted result.
// Depends on xsd_pkg for the opcodes and the row width.
`timescale 1ns / 1ps

module xsd_checker #(
  parameter int unsigned SCREEN_WIDTH  = xsd_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = xsd_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [3:0] row_index_i,
  input  logic [7:0] sprite_bits_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       row_collision_i,
  input  logic       sprite_collision_i,
  input  logic       pixel_value_i,
  output int         mismatch_count_o,
  output int         flags_pending_o
);
  import xsd_pkg::*;

  localparam int unsigned FB_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic row_hit;
    logic sprite_hit;
    logic pixel;
  } pixel_flags_t;

  logic         frame_model [FB_SIZE];
  logic         collision_acc;
  pixel_flags_t flags_q [$];
  pixel_flags_t want_flags;
  pixel_flags_t got_flags;
  int           mismatches;

  function automatic void blank_frame();
    int unsigned i;
    for (i = 0; i < FB_SIZE; i++) frame_model[i] = 1'b0;
  endfunction

  // Apply one item to the mirrored store and return the flags it should produce.
  function automatic pixel_flags_t xor_draw_predict(logic [1:0] op, logic [7:0] x,
                                                    logic [7:0] y, logic [3:0] row,
                                                    logic [7:0] bits);
    pixel_flags_t res;
    int unsigned  addr;
    int unsigned  p;
    res = '0;
    case (op)
      OP_DRAW: begin
        for (p = 0; p < ROW_BITS; p++) begin
          if (bits[ROW_BITS-1-p]) begin
            addr = (int'(x) + (int'(y) + int'(row)) * SCREEN_WIDTH + p) % FB_SIZE;
            if (frame_model[addr]) res.row_hit = 1'b1;
            frame_model[addr] = ~frame_model[addr];
          end
        end
        // row 0 starts a new sprite
        if (row == 4'd0) collision_acc = 1'b0;
        collision_acc  = collision_acc | res.row_hit;
        res.sprite_hit = collision_acc;
      end
      OP_CLEAR: blank_frame();
      OP_READ: res.pixel = frame_model[(int'(x) + int'(y) * SCREEN_WIDTH) % FB_SIZE];
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_frame();
      collision_acc = 1'b0;
      flags_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        flags_q.push_back(xor_draw_predict(opcode_i, x_pos_i, y_pos_i, row_index_i,
                                           sprite_bits_i));
      end
      if (out_valid_i && out_ready_i) begin
        got_flags = '{row_collision_i, sprite_collision_i, pixel_value_i};
        if (flags_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result row %b sprite %b pixel %b", $realtime,
                     got_flags.row_hit, got_flags.sprite_hit, got_flags.pixel);
          end
          mismatches++;
        end else begin
          want_flags = flags_q.pop_front();
          if (got_flags.row_hit !== want_flags.row_hit ||
              got_flags.sprite_hit !== want_flags.sprite_hit ||
              got_flags.pixel !== want_flags.pixel) begin
            if (mismatches < 10) begin
              $display("%0t: expected row %b sprite %b pixel %b, got row %b sprite %b pixel %b",
                       $realtime, want_flags.row_hit, want_flags.sprite_hit, want_flags.pixel,
                       got_flags.row_hit, got_flags.sprite_hit, got_flags.pixel);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o = mismatches;
    flags_pending_o  = flags_q.size();
  end

endmodule

FILE: tb/xor_sprite_draw_framebuffer_core_tb.sv
// Testbench top for xor_sprite_draw_framebuffer_core: drives directed and random
// draw, clear and read items with random idling, and takes the verdict from xsd_checker.
// Depends on xsd_pkg, the core and tb/xsd_checker.sv.
`timescale 1ns / 1ps

module xor_sprite_draw_framebuffer_core_tb;
  import xsd_pkg::*;

  localparam int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH;
  localparam int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          ITEM_TARGET   = 1050;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          DRAIN_CYCLES  = 40;

  typedef enum int {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_RUNS} rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i = OP_DRAW;
  logic [7:0] x_pos_i = '0;
  logic [7:0] y_pos_i = '0;
  logic [3:0] row_index_i = '0;
  logic [7:0] sprite_bits_i = '0;
  logic       last_row_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       row_collision_o;
  logic       sprite_collision_o;
  logic       pixel_value_o;

  int         mismatch_count;
  int         flags_pending;
  int         items_sent = 0;
  int         burst_left = 0;
  int         cycle_count = 0;
  int         rx_cycle = 0;
  int         rx_hold = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  logic [7:0] last_x = '0;
  logic [7:0] last_y = '0;

  always #10 clk_i = ~clk_i;

  xor_sprite_draw_framebuffer_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .x_pos_i           (x_pos_i),
    .y_pos_i           (y_pos_i),
    .row_index_i       (row_index_i),
    .sprite_bits_i     (sprite_bits_i),
    .last_row_i        (last_row_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .row_collision_o   (row_collision_o),
    .sprite_collision_o(sprite_collision_o),
    .pixel_value_o     (pixel_value_o)
  );

  xsd_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .opcode_i          (opcode_i),
    .x_pos_i           (x_pos_i),
    .y_pos_i           (y_pos_i),
    .row_index_i       (row_index_i),
    .sprite_bits_i     (sprite_bits_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .row_collision_i   (row_collision_o),
    .sprite_collision_i(sprite_collision_o),
    .pixel_value_i     (pixel_value_o),
    .mismatch_count_o  (mismatch_count),
    .flags_pending_o   (flags_pending)
  );

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue_item(logic [1:0] op, logic [7:0] x, logic [7:0] y, logic [3:0] row,
                            logic [7:0] bits, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    opcode_i      <= op;
    x_pos_i       <= x;
    y_pos_i       <= y;
    row_index_i   <= row;
    sprite_bits_i <= bits;
    last_row_i    <= last;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Draw rows first_row .. first_row+nrows-1, stopping at row 15; mark the final one unless broken.
  task automatic draw_sprite(logic [7:0] x, logic [7:0] y, int first_row, int nrows,
                             bit broken);
    int         r;
    logic [7:0] bits;
    for (r = first_row; r < first_row + nrows && r < 16; r++) begin
      case ($urandom_range(0, 9))
        0:       bits = 8'h00;
        1:       bits = 8'hFF;
        default: bits = 8'($urandom);
      endcase
      issue_item(OP_DRAW, x, y, 4'(r), bits,
                 !broken && (r == first_row + nrows - 1 || r == 15));
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_cycle % 256 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:      out_ready_i <= 1'b1;
      RX_ALTERNATE: out_ready_i <= rx_cycle[1];
      RX_RANDOM:    out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int         kind;
    int         nrows;
    int         k;
    int         reads;
    logic [7:0] sx;
    logic [7:0] sy;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fresh store, set pixels, collisions, wrap, clear, unused opcode
    issue_item(OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0);
    issue_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b0);
    issue_item(OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0);
    issue_item(OP_READ, 8'd7, 8'd0, 4'd0, 8'h00, 1'b0);
    issue_item(OP_READ, 8'd8, 8'd0, 4'd0, 8'h00, 1'b0);
    issue_item(OP_DRAW, 8'd0, 8'd0, 4'd0, 8'h81, 1'b0);
    issue_item(OP_DRAW, 8'd0, 8'd0, 4'd1, 8'h3C, 1'b1);
    issue_item(OP_READ, 8'd2, 8'd1, 4'd0, 8'h00, 1'b1);
    issue_item(OP_DRAW, 8'd255, 8'd255, 4'd15, 8'hAA, 1'b1);
    issue_item(OP_DRAW, 8'd255, 8'd255, 4'd15, 8'h55, 1'b1);
    issue_item(OP_READ, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
    issue_item(OP_DRAW, 8'd60, 8'd31, 4'd0, 8'hFF, 1'b1);
    issue_item(OP_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0);
    issue_item(OP_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
    issue_item(OP_DRAW, 8'd60, 8'd31, 4'd0, 8'h0F, 1'b0);
    issue_item(OP_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
    issue_item(OP_READ, 8'd1, 8'd0, 4'd0, 8'h00, 1'b0);
    // collision flag survives the clear on a row that is not row 0
    issue_item(OP_DRAW, 8'd10, 8'd5, 4'd5, 8'hF0, 1'b0);
    issue_item(OP_DRAW, 8'd10, 8'd4, 4'd6, 8'hF0, 1'b1);
    issue_item(OP_DRAW, 8'd10, 8'd10, 4'd0, 8'h00, 1'b1);
    issue_item(OP_UNUSED, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        // well-formed sprite, often over an earlier one to force collisions
        case ($urandom_range(0, 2))
          0: begin sx = last_x; sy = last_y; end
          1: begin sx = 8'($urandom_range(0, 63)); sy = 8'($urandom_range(0, 31)); end
          default: begin sx = 8'($urandom); sy = 8'($urandom); end
        endcase
        last_x = sx;
        last_y = sy;
        nrows = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        draw_sprite(sx, sy, 0, nrows, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          reads = $urandom_range(1, 3);
          for (k = 0; k < reads; k++) begin
            issue_item(OP_READ, 8'(sx + $urandom_range(0, 7)),
                       8'(sy + $urandom_range(0, nrows - 1)), 4'($urandom), 8'($urandom),
                       1'($urandom));
          end
        end
      end else if (kind < 85) begin
        // broken sequence: starts mid-sprite or never marks its last row
        draw_sprite(8'($urandom), 8'($urandom), $urandom_range(0, 8), $urandom_range(1, 6),
                    1'($urandom));
      end else if (kind < 87) begin
        issue_item(OP_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                   1'($urandom));
      end else begin
        issue_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 4'($urandom),
                   8'($urandom), 1'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    while (flags_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && flags_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/xsd_pkg.sv
sv/xsd_datapath.sv
sv/xsd_ctrl.sv
sv/xor_sprite_draw_framebuffer_core.sv
tb/xsd_checker.sv
tb/xor_sprite_draw_framebuffer_core_tb.sv
